// ===== sv/sfr_pkg.sv =====
// Package for the stream find-and-replace block: widths, register codes and control types.
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int BYTE_W              = 8;
  localparam int LEN_W               = 4;
  localparam int CFG_IDX_W           = 8;
  localparam int CFG_W               = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 8'd0,
    REG_PATTERN_LEN       = 8'd1,
    REG_REPLACEMENT_BYTES = 8'd2,
    REG_REPLACEMENT_LEN   = 8'd3
  } cfg_reg_t;

  // Control for one window cell.
  typedef struct packed {
    logic en;      // a word is accepted this cycle
    logic shift;   // take the neighbour's byte (oldest byte leaves)
    logic older;   // cell holds a pending byte
    logic in_use;  // cell lies within the pattern length
  } cell_ctrl_t;

  // Control for loading the result buffer.
  typedef struct packed {
    logic load;
    logic last;
    logic bare;
  } burst_ctrl_t;

endpackage

// ===== sv/sfr_if.sv =====
// Channel interfaces: input bytes, result words and configuration writes.
interface sfr_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_result_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                      out_valid;
  logic                      out_last;
  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] index;
  logic [sfr_pkg::CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sfr_cell.sv =====
// One window cell: holds a pending byte, compares it with its pattern byte.
module sfr_cell (
  input  logic                       clk,
  input  sfr_pkg::cell_ctrl_t        ctrl,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] new_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] nb_post,
  output logic [sfr_pkg::BYTE_W-1:0] post,
  output logic                       hit
);

  logic [sfr_pkg::BYTE_W-1:0] data;

  // A cell without a pending byte shows the incoming byte, as if it had been pushed.
  assign post = ctrl.older ? data : new_byte;
  assign hit  = !ctrl.in_use || (post == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      data <= ctrl.shift ? nb_post : post;
    end
  end

endmodule

// ===== sv/sfr_burst.sv =====
// Result buffer: holds the words caused by one input word and hands them out one a cycle while the receiver is ready.
module sfr_burst #(
  parameter int DEPTH = sfr_pkg::MAX_PATTERN_DEF,
  parameter int BN_W  = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfr_pkg::burst_ctrl_t       ctrl,
  input  logic [BN_W-1:0]            load_n,
  input  logic [sfr_pkg::BYTE_W-1:0] load_bytes [DEPTH],
  output logic                       room,
  sfr_result_if.source               dst
);

  logic [BN_W-1:0]            n;
  logic [sfr_pkg::BYTE_W-1:0] bytes [DEPTH];
  logic                       last;
  logic                       bare;
  logic                       take;

  assign take = dst.valid && dst.ready;
  // Room for a new input word when the buffer is empty or its final buffered word leaves this cycle.
  assign room = (n == '0) || ((n == BN_W'(1)) && dst.ready);

  assign dst.valid     = (n != '0);
  assign dst.out_byte  = bytes[0];
  assign dst.out_valid = !bare;
  assign dst.out_last  = last && (n == BN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (ctrl.load) begin
      n <= load_n;
    end else if (take) begin
      n <= n - BN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bytes <= load_bytes;
      last  <= ctrl.last;
      bare  <= ctrl.bare;
    end else if (take) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        bytes[i] <= bytes[i + 1];
      end
    end
  end

endmodule

// ===== sv/stream_find_replace.sv =====
// Streaming find-and-replace over a byte string, built as a row of window cells.
// The first result word of an input word is offered in the cycle after it is accepted.
// Throughput: one byte per cycle while the result buffer has room; an input word that causes
// k result words (a replacement of k bytes, or an end-of-string flush) holds the input until
// its final result word leaves the single result buffer, drained one word a cycle when ready.
// Reset: empties the window and result buffer and loads the default register values.
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sfr_byte_if.sink     src,
  sfr_result_if.source dst,
  sfr_cfg_if.sink      cfg
);

  localparam int BYTE_W  = sfr_pkg::BYTE_W;
  localparam int LEN_W   = sfr_pkg::LEN_W;
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int BURST_D = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int BN_W    = $clog2(BURST_D + 1);

  logic [sfr_pkg::CFG_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]          pattern_len;
  logic [sfr_pkg::CFG_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]          replacement_len;
  logic [CNT_W-1:0]          count;
  logic [LEN_W-1:0]          wr_len;

  logic                accept;
  logic                room;
  logic [LEN_W-1:0]    count_p1;
  logic                full;
  logic                match;
  logic                replace;
  logic [BYTE_W-1:0]   post [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;

  sfr_pkg::burst_ctrl_t bctrl;
  logic [BN_W-1:0]      load_n;
  logic [BYTE_W-1:0]    load_bytes [BURST_D];

  assign cfg.ready = 1'b1;
  assign src.ready = room;
  assign accept    = src.valid && src.ready;

  // ---------------- configuration registers ----------------
  assign wr_len = cfg.data[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_len       <= LEN_W'(1);
      replacement_bytes <= '0;
      replacement_len   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        sfr_pkg::REG_PATTERN_BYTES: begin
          pattern_bytes <= cfg.data;
        end
        sfr_pkg::REG_PATTERN_LEN: begin
          if (wr_len == '0) begin
            pattern_len <= LEN_W'(1);
          end else if (wr_len > LEN_W'(MAX_PATTERN)) begin
            pattern_len <= LEN_W'(MAX_PATTERN);
          end else begin
            pattern_len <= wr_len;
          end
        end
        sfr_pkg::REG_REPLACEMENT_BYTES: begin
          replacement_bytes <= cfg.data;
        end
        sfr_pkg::REG_REPLACEMENT_LEN: begin
          if (wr_len > LEN_W'(MAX_REPLACEMENT)) begin
            replacement_len <= LEN_W'(MAX_REPLACEMENT);
          end else begin
            replacement_len <= wr_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- window cells ----------------
  assign count_p1 = LEN_W'(count) + LEN_W'(1);
  assign full     = (count_p1 >= pattern_len);
  assign match    = &hits;
  assign replace  = full && match;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sfr_pkg::cell_ctrl_t cctrl;
    logic [BYTE_W-1:0]   nb;

    assign cctrl.en     = accept;
    assign cctrl.shift  = full && !match;
    assign cctrl.older  = (CNT_W'(g) < count);
    assign cctrl.in_use = (LEN_W'(g) < pattern_len);

    if (g == MAX_PATTERN - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = post[g + 1];
    end

    sfr_cell u_cell (
      .clk      (clk),
      .ctrl     (cctrl),
      .pat_byte (pattern_bytes[BYTE_W*g +: BYTE_W]),
      .new_byte (src.in_byte),
      .nb_post  (nb),
      .post     (post[g]),
      .hit      (hits[g])
    );
  end

  // A write to the pattern length drops any pending bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg.valid && cfg.ready && (cfg.index == sfr_pkg::REG_PATTERN_LEN)) begin
      count <= '0;
    end else if (accept) begin
      if (replace || src.in_last) begin
        count <= '0;
      end else if (!full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // ---------------- result words for the accepted byte ----------------
  always_comb begin
    bctrl.load = accept;
    bctrl.last = src.in_last;
    bctrl.bare = 1'b0;
    load_n     = '0;
    for (int i = 0; i < BURST_D; i++) begin
      load_bytes[i] = '0;
      if (replace) begin
        if (i < MAX_REPLACEMENT) begin
          load_bytes[i] = replacement_bytes[BYTE_W*i +: BYTE_W];
        end
      end else if (i < MAX_PATTERN) begin
        load_bytes[i] = post[i];
      end
    end
    if (replace) begin
      load_n = BN_W'(replacement_len);
      // Nothing left to send at the end of the string: a bare end marker.
      if (src.in_last && (replacement_len == '0)) begin
        load_n        = BN_W'(1);
        bctrl.bare    = 1'b1;
        load_bytes[0] = '0;
      end
    end else if (src.in_last) begin
      load_n = BN_W'(count_p1);
    end else if (full) begin
      load_n = BN_W'(1);
    end
  end

  sfr_burst #(
    .DEPTH (BURST_D),
    .BN_W  (BN_W)
  ) u_burst (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (bctrl),
    .load_n     (load_n),
    .load_bytes (load_bytes),
    .room       (room),
    .dst        (dst)
  );

  // ---------------- assertions ----------------
  a_window_below_len: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(count) < pattern_len)
    else $error("window holds a full pattern length after a step");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && src.in_last) |=> (count == '0))
    else $error("window not empty after end of string");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && !dst.out_valid) |-> (dst.out_last && (dst.out_byte == '0)))
    else $error("bare marker without end flag or with data");

  a_last_frees_room: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.ready && dst.out_last) |-> src.ready)
    else $error("input held after the final word of a string left");

endmodule
